// ----- sv/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Function codes, result kinds, widths and the controller state type.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned DefNumSlots  = 16;
  localparam int unsigned MaxResults   = 16;
  localparam int unsigned HandleW      = 8;
  localparam int unsigned TimeW        = 32;

  typedef enum logic [1:0] {
    FUNC_REGISTER = 2'd0,
    FUNC_TICK     = 2'd1,
    FUNC_SERVICE  = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_NONE_DUE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_OUT
  } state_e;

  // Command from the controller to every cell.
  typedef struct packed {
    logic                 load;      // write new entry into the selected free cell
    logic                 scan;      // start/continue scan (cells compute due flag)
    logic                 clear_sel; // free the cell that won the scan
    logic [HandleW-1:0]   handle;
    logic [TimeW-1:0]     delay;
    logic [TimeW-1:0]     now;
  } cell_cmd_t;

endpackage

// ----- sv/dtq_if.sv -----
// ----------------------------------------------------------------------------
// dtq_in_if / dtq_out_if: valid/ready channels of the deadline timer queue
// One transaction moves one input item or one result item.
// ----------------------------------------------------------------------------
interface dtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  handle;
  logic [31:0] delay;
  modport source (output valid, func, handle, delay, input ready);
  modport sink   (input valid, func, handle, delay, output ready);
endinterface

interface dtq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] fired_handle;
  logic       last;
  modport source (output valid, kind, fired_handle, last, input ready);
  modport sink   (input valid, kind, fired_handle, last, output ready);
endinterface

// ----- sv/deadline_timer_queue.sv -----
// ----------------------------------------------------------------------------
// deadline_timer_queue: timer slot table with earliest-deadline service
// Register, tick and service of up to NUM_SLOTS timed callback slots.
// ----------------------------------------------------------------------------
// A tick item advances the time by one and the input is ready again in the
// next cycle. A register item returns one result through a held output
// register in the cycle after acceptance; the input stays blocked until that
// result is taken. A service item runs one scan of the cell chain per fired
// slot and a closing scan that finds no further due slot, unless the limit
// is reached (the due flags are registered, then the best-candidate record
// ripples through one stage register per four cells); each scan is followed
// by a pick state and, for a fired slot, a state that frees it. A fired
// result is shown only once the next scan tells whether it is the last one,
// and it must be taken before the next slot is picked. Output stalls
// lengthen a service. One item is in flight at a time; the input is ready
// only while the controller is idle and no result waits. A slot is due
// when (now - request) mod 2^32 >= delay; among due slots the one overdue
// longest fires first, ties to the lower slot; at most 16 fire per service.
// ----------------------------------------------------------------------------
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int unsigned NUM_SLOTS = DefNumSlots
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtq_in_if.sink     in_i,
  dtq_out_if.source  out_o
);

  localparam int unsigned IdxW  = $clog2(NUM_SLOTS);
  localparam int unsigned ScanN = (NUM_SLOTS + 3) / 4 + 2;
  localparam int unsigned CntW  = $clog2(ScanN + 1);
  localparam int unsigned NW    = $clog2(MaxResults + 1);

  state_e            state_q, state_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]     n_q, n_d;
  logic              ov_q, ov_d;
  logic [1:0]        okind_q, okind_d;
  logic [HandleW-1:0] oh_q, oh_d;
  logic              olast_q, olast_d;
  logic [IdxW-1:0]   win_q, win_d;
  cell_cmd_t         cmd;
  logic              full, bv;
  logic [IdxW-1:0]   bidx;
  logic [HandleW-1:0] bh;
  logic              in_hs, out_hs;

  assign in_hs  = in_i.valid && in_i.ready;
  assign out_hs = out_o.valid && out_o.ready;

  dtq_chain #(.NumSlots(NUM_SLOTS)) u_chain (
    .clk_i, .rst_ni, .cmd_i(cmd), .win_idx_i(win_q),
    .full_o(full), .best_valid_o(bv), .best_idx_o(bidx), .best_handle_o(bh)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      now_q   <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oh_q    <= oh_d;
    olast_q <= olast_d;
    win_q   <= win_d;
  end

  always_comb begin
    state_d = state_q;
    now_d   = now_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    ov_d    = ov_q;
    okind_d = okind_q;
    oh_d    = oh_q;
    olast_d = olast_q;
    win_d   = win_q;
    cmd.load      = 1'b0;
    cmd.scan      = 1'b0;
    cmd.clear_sel = 1'b0;
    cmd.handle    = in_i.handle;
    cmd.delay     = in_i.delay;
    cmd.now       = now_q;
    in_i.ready    = (state_q == ST_IDLE) && !ov_q;
    if (out_hs) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          case (func_e'(in_i.func))
            FUNC_REGISTER: begin
              cmd.load = !full;
              okind_d  = full ? KIND_REJECTED : KIND_ACCEPTED;
              oh_d     = full ? '0 : in_i.handle;
              olast_d  = 1'b1;
              ov_d     = 1'b1;
            end
            FUNC_TICK: now_d = now_q + 1'b1;
            FUNC_SERVICE: begin
              state_d = ST_SCAN;
              cnt_d   = '0;
              n_d     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ScanN - 1)) state_d = ST_PICK;
      end
      ST_PICK: begin
        // keep the due flags live so the chain result stays steady
        cmd.scan = 1'b1;
        if (ov_q && !out_hs) begin
          // previous fired result still waiting for the receiver
        end else if (bv && n_q != NW'(MaxResults)) begin
          okind_d = KIND_FIRED;
          oh_d    = bh;
          olast_d = (n_q == NW'(MaxResults - 1));
          win_d   = bidx;
          ov_d    = 1'b1;
          n_d     = n_q + 1'b1;
          state_d = ST_OUT;
        end else if (n_q == '0) begin
          okind_d = KIND_NONE_DUE;
          oh_d    = '0;
          olast_d = 1'b1;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          // previous fired result went out marked last
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        cmd.clear_sel = 1'b1;
        cnt_d = '0;
        state_d = (n_q == NW'(MaxResults)) ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A fired result is held until the next scan tells whether more fire;
  // the output is exposed only once its last flag is settled.
  logic hold;
  assign hold = (okind_q == KIND_FIRED) && !olast_q && (state_q != ST_PICK);
  logic last_now;
  assign last_now = olast_q || ((okind_q == KIND_FIRED) && (state_q == ST_PICK) &&
                    !(bv && n_q != NW'(MaxResults)));

  assign out_o.valid        = ov_q && !hold;
  assign out_o.kind         = okind_q;
  assign out_o.fired_handle = oh_q;
  assign out_o.last         = last_now;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |-> state_q == ST_IDLE) else $error("input accepted while busy");
  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && in_i.func == FUNC_TICK) |=> now_q == $past(now_q) + 1'b1)
    else $error("tick did not advance time");
  a_fired_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MaxResults)) else $error("too many fired results");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid) else $error("ready with pending result");
`endif

endmodule

// ----- sv/dtq_cell.sv -----
// ----------------------------------------------------------------------------
// dtq_cell: one timer slot plus one link of the earliest-deadline chain
// Holds a slot; compares its registered overdue value against the best
// candidate handed in from the lower neighbor and hands the winner on.
// ----------------------------------------------------------------------------
module dtq_cell import dtq_pkg::*; #(
  parameter int unsigned IdxW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic               free_sel_i,   // this cell is the lowest free one
  input  logic [IdxW-1:0]    my_idx_i,
  input  logic               win_idx_hit_i, // winner index equals this cell
  // chain from lower neighbor
  input  logic               c_valid_i,
  input  logic [TimeW-1:0]   c_over_i,
  input  logic [IdxW-1:0]    c_idx_i,
  input  logic [HandleW-1:0] c_handle_i,
  output logic               c_valid_o,
  output logic [TimeW-1:0]   c_over_o,
  output logic [IdxW-1:0]    c_idx_o,
  output logic [HandleW-1:0] c_handle_o,
  output logic               busy_o
);

  logic               valid_q;
  logic [HandleW-1:0] handle_q;
  logic [TimeW-1:0]   req_q, dly_q;
  logic               due_q;
  logic [TimeW-1:0]   over_q;
  logic [TimeW-1:0]   elapsed;
  logic               take;

  assign elapsed = cmd_i.now - req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      due_q   <= 1'b0;
    end else begin
      if (cmd_i.load && free_sel_i) valid_q <= 1'b1;
      else if (cmd_i.clear_sel && win_idx_hit_i) valid_q <= 1'b0;
      // due flag registered so the chain path holds one compare only
      due_q <= cmd_i.scan && valid_q && (elapsed >= dly_q) &&
               !(cmd_i.clear_sel && win_idx_hit_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && free_sel_i) begin
      handle_q <= cmd_i.handle;
      req_q    <= cmd_i.now;
      dly_q    <= cmd_i.delay;
    end
    over_q <= elapsed - dly_q;
  end

  // strict greater keeps ties on the lower slot
  assign take       = due_q && (!c_valid_i || over_q > c_over_i);
  assign c_valid_o  = c_valid_i || due_q;
  assign c_over_o   = take ? over_q : c_over_i;
  assign c_idx_o    = take ? my_idx_i : c_idx_i;
  assign c_handle_o = take ? handle_q : c_handle_i;
  assign busy_o     = valid_q;

endmodule

// ----- sv/dtq_chain.sv -----
// ----------------------------------------------------------------------------
// dtq_chain: row of timer cells with a registered stage every few cells
// Passes the best-candidate record from slot 0 upward; a stage register
// in front of every group of four cells keeps the compare chain short.
// ----------------------------------------------------------------------------
module dtq_chain import dtq_pkg::*; #(
  parameter int unsigned NumSlots = DefNumSlots,
  localparam int unsigned IdxW = $clog2(NumSlots),
  localparam int unsigned Grp = 4,
  localparam int unsigned NumStg = (NumSlots + Grp - 1) / Grp
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic [IdxW-1:0]    win_idx_i,
  output logic               full_o,
  output logic               best_valid_o,
  output logic [IdxW-1:0]    best_idx_o,
  output logic [HandleW-1:0] best_handle_o
);

  logic [NumSlots-1:0] busy, free_sel;
  logic [NumSlots:0]               cv;
  logic [NumSlots:0][TimeW-1:0]    co;
  logic [NumSlots:0][IdxW-1:0]     ci;
  logic [NumSlots:0][HandleW-1:0]  ch;
  // values entering each cell after optional stage register
  logic [NumSlots-1:0]             iv;
  logic [NumSlots-1:0][TimeW-1:0]  io;
  logic [NumSlots-1:0][IdxW-1:0]   ii;
  logic [NumSlots-1:0][HandleW-1:0] ih;
  logic [NumStg-1:0]               sv_q;
  logic [NumStg-1:0][TimeW-1:0]    so_q;
  logic [NumStg-1:0][IdxW-1:0]     si_q;
  logic [NumStg-1:0][HandleW-1:0]  sh_q;

  // lowest free slot, one-hot
  always_comb begin
    logic found;
    found = 1'b0;
    for (int s = 0; s < NumSlots; s++) begin
      free_sel[s] = !busy[s] && !found;
      if (!busy[s]) found = 1'b1;
    end
  end
  assign full_o = &busy;

  assign cv[0] = 1'b0;
  assign co[0] = '0;
  assign ci[0] = '0;
  assign ch[0] = '0;

  for (genvar g = 0; g < NumStg; g++) begin : g_stg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[g] <= 1'b0;
      else         sv_q[g] <= cv[g*Grp];
    end
    always_ff @(posedge clk_i) begin
      so_q[g] <= co[g*Grp];
      si_q[g] <= ci[g*Grp];
      sh_q[g] <= ch[g*Grp];
    end
  end

  for (genvar s = 0; s < NumSlots; s++) begin : g_cell
    if (s % Grp == 0) begin : g_reg
      assign iv[s] = sv_q[s/Grp];
      assign io[s] = so_q[s/Grp];
      assign ii[s] = si_q[s/Grp];
      assign ih[s] = sh_q[s/Grp];
    end else begin : g_comb
      assign iv[s] = cv[s];
      assign io[s] = co[s];
      assign ii[s] = ci[s];
      assign ih[s] = ch[s];
    end
    dtq_cell #(.IdxW(IdxW)) u_cell (
      .clk_i, .rst_ni, .cmd_i,
      .free_sel_i   (free_sel[s]),
      .my_idx_i     (IdxW'(s)),
      .win_idx_hit_i(win_idx_i == IdxW'(s)),
      .c_valid_i    (iv[s]), .c_over_i(io[s]), .c_idx_i(ii[s]), .c_handle_i(ih[s]),
      .c_valid_o    (cv[s+1]), .c_over_o(co[s+1]), .c_idx_o(ci[s+1]),
      .c_handle_o   (ch[s+1]),
      .busy_o       (busy[s])
    );
  end

  assign best_valid_o  = cv[NumSlots];
  assign best_idx_o    = ci[NumSlots];
  assign best_handle_o = ch[NumSlots];

endmodule
